// ----- src/qthd_pkg.sv -----
// qthd_pkg: shared types and constants for the quarter tile hsla downsampler
// used by qthd_control, qthd_datapath and quarter_tile_hsla_downsample
`default_nettype none

package qthd_pkg;

   localparam int DIM_W     = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CNT_W     = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 9'd256;

   localparam logic [15:0] HUE_FULL = 16'd46080;
   localparam logic [15:0] HUE_HALF = 16'd23040;

   localparam logic       OP_LOAD = 1'b0;
   localparam logic       OP_PICK = 1'b1;

   localparam logic [CNT_W-1:0] DIV_LAST  = 4'd15;
   localparam logic [CNT_W-1:0] READ_LAST = 4'd3;

   typedef struct packed {
      logic        operation;
      logic [15:0] coord_x;
      logic [15:0] coord_y;
      logic [15:0] in_hue;
      logic [15:0] in_sat;
      logic [15:0] in_lum;
      logic [15:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [15:0] out_hue;
      logic [15:0] out_sat;
      logic [15:0] out_lum;
      logic [15:0] out_alpha;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_DIVIDE,
      ST_BASE,
      ST_READ,
      ST_DRAIN,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       mem_write;
      logic       div_step;
      logic       base_load;
      logic       mem_read;
      logic [1:0] rd_idx;
      logic       push;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_pick;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- src/qthd_control.sv -----
// qthd_control: sequencing state machine for loads and picks
// depends on qthd_pkg; drives qthd_datapath through ctrl_cmd_type
`default_nettype none

module qthd_control import qthd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.req_pick == OP_PICK) ? ST_DIVIDE : ST_WRITE;
            end
         end
         ST_WRITE:  state_in = ST_IDLE;
         ST_DIVIDE: begin
            if (cnt_ff == DIV_LAST) state_in = ST_BASE;
         end
         ST_BASE:   state_in = ST_READ;
         ST_READ: begin
            if (cnt_ff == READ_LAST) state_in = ST_DRAIN;
         end
         ST_DRAIN:  state_in = ST_PUSH;
         ST_PUSH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cnt_in    = '0;
            cmd.latch = req_valid;
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = (cnt_ff == DIV_LAST) ? '0 : cnt_ff + 1'b1;
         end
         ST_BASE: begin
            cmd.base_load = 1'b1;
            cnt_in        = '0;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            cmd.rd_idx   = cnt_ff[1:0];
            cnt_in       = (cnt_ff == READ_LAST) ? '0 : cnt_ff + 1'b1;
         end
         ST_DRAIN: begin
            cnt_in = '0;
         end
         ST_PUSH: begin
            cmd.push = status.out_free;
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/qthd_datapath.sv -----
// qthd_datapath: config registers, pixel memory, modulo unit, averaging and output register
// depends on qthd_pkg; commanded by qthd_control
`default_nettype none

module qthd_datapath import qthd_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  req_type              req_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  ctrl_cmd_type         cmd,
   output ctrl_status_type      status
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_WIDTH);

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
      logic [DIM_W-1:0] e;
      e = {v[DIM_W-1:1], 1'b0};
      if (e < DIM_W'(2)) e = DIM_W'(2);
      if (int'(e) > maxv) e = DIM_W'(maxv);
      return e;
   endfunction

   function automatic logic [DIM_W-2:0] mod_step(input logic [DIM_W-2:0] r, input logic b,
                                                 input logic [DIM_W-2:0] d);
      logic [DIM_W-1:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) t = t - {1'b0, d};
      return t[DIM_W-2:0];
   endfunction

   // circular mean over the shorter arc
   function automatic logic [15:0] hue_pair(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      logic [17:0] wide;
      logic [16:0] mw;
      logic [15:0] d;
      logic [15:0] m;
      sum  = {1'b0, a} + {1'b0, b};
      d    = (a > b) ? a - b : b - a;
      wide = {1'b0, sum} + {2'b00, HUE_FULL};
      mw   = wide[17:1];
      m    = sum[16:1];
      if (d > HUE_HALF) begin
         if (mw >= {1'b0, HUE_FULL}) mw = mw - {1'b0, HUE_FULL};
         m = mw[15:0];
      end else if (d == HUE_HALF) begin
         if (m >= HUE_HALF) m = m - HUE_HALF;
      end
      return m;
   endfunction

   logic [63:0]       pixel_mem [DEPTH];

   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;
   logic [15:0]       cx_ff, cx_in;
   logic [15:0]       cy_ff, cy_in;
   logic [63:0]       pix_ff, pix_in;
   logic [DIM_W-2:0]  rem_x_ff, rem_x_in;
   logic [DIM_W-2:0]  rem_y_ff, rem_y_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [63:0]       rd_data_ff;
   logic              acc_en_ff, acc_en_in;
   logic [1:0]        acc_idx_ff, acc_idx_in;
   logic [15:0]       hue_a_ff, hue_a_in;
   logic [15:0]       top_ff, top_in;
   logic [15:0]       bot_ff, bot_in;
   logic [17:0]       sum_s_ff, sum_s_in;
   logic [17:0]       sum_l_ff, sum_l_in;
   logic [17:0]       sum_a_ff, sum_a_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0]  eff_w, eff_h;
   logic [DIM_W-2:0]  half_w, half_h;
   logic              load_ok;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [15:0]       hue_load;

   assign eff_w   = eff_dim(width_ff, MAX_WIDTH);
   assign eff_h   = eff_dim(height_ff, MAX_HEIGHT);
   assign half_w  = eff_w[DIM_W-1:1];
   assign half_h  = eff_h[DIM_W-1:1];
   assign load_ok = (cx_ff < 16'(eff_w)) && (cy_ff < 16'(eff_h));
   assign wr_addr = ADDR_W'(cy_ff[DIM_W-1:0]) * STRIDE + ADDR_W'(cx_ff[DIM_W-1:0]);
   assign rd_addr = base_ff + (cmd.rd_idx[1] ? STRIDE : '0) + ADDR_W'(cmd.rd_idx[0]);
   assign hue_load = (req_data.in_hue >= HUE_FULL) ? req_data.in_hue - HUE_FULL
                                                   : req_data.in_hue;

   assign status.req_pick = req_data.operation;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;

   // config registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture, modulo and base address
   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      pix_in   = pix_ff;
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      base_in  = base_ff;
      if (cmd.latch) begin
         cx_in    = req_data.coord_x;
         cy_in    = req_data.coord_y;
         pix_in   = {req_data.in_alpha, req_data.in_lum, req_data.in_sat, hue_load};
         rem_x_in = '0;
         rem_y_in = '0;
      end else if (cmd.div_step) begin
         cx_in    = {cx_ff[14:0], 1'b0};
         cy_in    = {cy_ff[14:0], 1'b0};
         rem_x_in = mod_step(rem_x_ff, cx_ff[15], half_w);
         rem_y_in = mod_step(rem_y_ff, cy_ff[15], half_h);
      end
      if (cmd.base_load) begin
         base_in = ADDR_W'({rem_y_ff, 1'b0}) * STRIDE + ADDR_W'({rem_x_ff, 1'b0});
      end
   end

   // accumulation of the four pixels
   always_comb begin
      acc_en_in  = cmd.mem_read;
      acc_idx_in = cmd.rd_idx;
      hue_a_in   = hue_a_ff;
      top_in     = top_ff;
      bot_in     = bot_ff;
      sum_s_in   = sum_s_ff;
      sum_l_in   = sum_l_ff;
      sum_a_in   = sum_a_ff;
      if (acc_en_ff) begin
         if (acc_idx_ff == 2'd0) begin
            sum_s_in = {2'b00, rd_data_ff[31:16]};
            sum_l_in = {2'b00, rd_data_ff[47:32]};
            sum_a_in = {2'b00, rd_data_ff[63:48]};
         end else begin
            sum_s_in = sum_s_ff + {2'b00, rd_data_ff[31:16]};
            sum_l_in = sum_l_ff + {2'b00, rd_data_ff[47:32]};
            sum_a_in = sum_a_ff + {2'b00, rd_data_ff[63:48]};
         end
         unique case (acc_idx_ff)
            2'd0:    hue_a_in = rd_data_ff[15:0];
            2'd1:    top_in   = hue_pair(hue_a_ff, rd_data_ff[15:0]);
            2'd2:    hue_a_in = rd_data_ff[15:0];
            2'd3:    bot_in   = hue_pair(hue_a_ff, rd_data_ff[15:0]);
            default: ;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.push) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_hue   = hue_pair(top_ff, bot_ff);
         rsp_data_in.out_sat   = sum_s_ff[17:2];
         rsp_data_in.out_lum   = sum_l_ff[17:2];
         rsp_data_in.out_alpha = sum_a_ff[17:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= IMAGE_DIM_RESET;
         height_ff    <= IMAGE_DIM_RESET;
         acc_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         acc_en_ff    <= acc_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      pix_ff      <= pix_in;
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      base_ff     <= base_in;
      acc_idx_ff  <= acc_idx_in;
      hue_a_ff    <= hue_a_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      sum_s_ff    <= sum_s_in;
      sum_l_ff    <= sum_l_in;
      sum_a_ff    <= sum_a_in;
      rsp_data_ff <= rsp_data_in;
   end

   // pixel memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_write && load_ok) begin
         pixel_mem[wr_addr] <= pix_ff;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= pixel_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/quarter_tile_hsla_downsample.sv -----
// quarter_tile_hsla_downsample: top level, controller plus datapath
// a pick captures the request, runs a 16-step restoring modulo on the coordinates, loads
// the base address, makes four reads through the single memory read port and registers the
// result; a load is captured, then written. No new request is taken until the last is done.
// reset: synchronous, clears control and output valid, sets both image dimensions to 256;
// the pixel memory is not cleared
`default_nettype none

module quarter_tile_hsla_downsample import qthd_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   qthd_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   qthd_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// testbench for quarter_tile_hsla_downsample: a directed table, then random load and pick traffic
// over several image sizes, each pick checked against a table value or an in-bench 2x2 hsla mean
// depends on qthd_pkg and the quarter_tile_hsla_downsample rtl
`default_nettype none

module testbench;
   import qthd_pkg::*;

   localparam int IMG_MAX      = 256;
   localparam int PHASE_ITEMS  = 94;
   localparam int SETTLE       = 30;
   localparam int NUM_DIRECTED = 27;
   localparam int NUM_PHASES   = 8;

   typedef struct packed {
      logic    typed;
      req_type stim;
      rsp_type want;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   rsp_type     image_copy   [0:IMG_MAX*IMG_MAX-1];
   bit          pixel_loaded [0:IMG_MAX*IMG_MAX-1];
   rsp_type     pending_picks [$];
   dir_row_type directed [0:NUM_DIRECTED-1];
   int          tile_w;
   int          tile_h;
   bit          calm;
   int          mismatch_count;
   int          pick_count;
   int          load_count;
   int          ignored_count;
   int          useful_count;
   int          phase_count;

   quarter_tile_hsla_downsample dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int clamp_dim(int v);
      v = v & ~1;
      if (v < 2) v = 2;
      if (v > IMG_MAX) v = IMG_MAX;
      return v;
   endfunction

   // circular mean over the shorter arc, ties take the smaller candidate
   function automatic logic [15:0] hue_midpoint(int unsigned a, int unsigned b);
      int unsigned gap;
      int unsigned mid;
      gap = (a > b) ? a - b : b - a;
      if (gap > HUE_HALF) begin
         mid = (a + b + HUE_FULL) >> 1;
         if (mid >= HUE_FULL) mid -= HUE_FULL;
      end else begin
         mid = (a + b) >> 1;
         if (gap == HUE_HALF) mid = mid % HUE_HALF;
      end
      return mid[15:0];
   endfunction

   function automatic logic [15:0] mean4(int unsigned a, int unsigned b, int unsigned c,
                                         int unsigned d);
      int unsigned total;
      total = (a + b + c + d) >> 2;
      return total[15:0];
   endfunction

   function automatic rsp_type downsample_pixel(logic [15:0] cx, logic [15:0] cy);
      int      bx;
      int      by;
      int      base;
      rsp_type tl;
      rsp_type tr;
      rsp_type bl;
      rsp_type br;
      rsp_type r;
      bx = (int'(cx) % (tile_w / 2)) * 2;
      by = (int'(cy) % (tile_h / 2)) * 2;
      base = by * IMG_MAX + bx;
      tl = image_copy[base];
      tr = image_copy[base + 1];
      bl = image_copy[base + IMG_MAX];
      br = image_copy[base + IMG_MAX + 1];
      r.out_hue   = hue_midpoint(hue_midpoint(tl.out_hue, tr.out_hue),
                                 hue_midpoint(bl.out_hue, br.out_hue));
      r.out_sat   = mean4(tl.out_sat, tr.out_sat, bl.out_sat, br.out_sat);
      r.out_lum   = mean4(tl.out_lum, tr.out_lum, bl.out_lum, br.out_lum);
      r.out_alpha = mean4(tl.out_alpha, tr.out_alpha, bl.out_alpha, br.out_alpha);
      return r;
   endfunction

   function automatic bit store_pixel(req_type r);
      rsp_type px;
      int      addr;
      if (r.coord_x >= tile_w || r.coord_y >= tile_h) begin
         ignored_count++;
         return 1'b0;
      end
      px.out_hue   = (r.in_hue >= HUE_FULL) ? r.in_hue - HUE_FULL : r.in_hue;
      px.out_sat   = r.in_sat;
      px.out_lum   = r.in_lum;
      px.out_alpha = r.in_alpha;
      addr = int'(r.coord_y) * IMG_MAX + int'(r.coord_x);
      image_copy[addr]   = px;
      pixel_loaded[addr] = 1'b1;
      load_count++;
      return 1'b1;
   endfunction

   function automatic dir_row_type mk(logic op, int x, int y, int h, int s, int l, int a,
                                      logic typed, int eh, int es, int el, int ea);
      dir_row_type row;
      row.typed          = typed;
      row.stim.operation = op;
      row.stim.coord_x   = 16'(x);
      row.stim.coord_y   = 16'(y);
      row.stim.in_hue    = 16'(h);
      row.stim.in_sat    = 16'(s);
      row.stim.in_lum    = 16'(l);
      row.stim.in_alpha  = 16'(a);
      row.want.out_hue   = 16'(eh);
      row.want.out_sat   = 16'(es);
      row.want.out_lum   = 16'(el);
      row.want.out_alpha = 16'(ea);
      return row;
   endfunction

   // hues clustered around an anchor so that ties, near ties and wraps come up often
   function automatic logic [15:0] rand_hue(int anchor);
      case ($urandom_range(7))
         0: return 16'($urandom_range(65535));
         1: return 16'(anchor);
         2: return 16'((anchor + HUE_HALF) % HUE_FULL);
         3: return 16'((anchor + HUE_HALF - 1) % HUE_FULL);
         4: return 16'((anchor + HUE_HALF + 1) % HUE_FULL);
         5: return $urandom_range(1) ? 16'(HUE_FULL - 1) : 16'd0;
         6: return (anchor < 65536 - HUE_FULL) ? 16'(anchor + HUE_FULL) : 16'(anchor);
         default: return 16'($urandom_range(HUE_FULL - 1));
      endcase
   endfunction

   function automatic logic [15:0] rand_chan();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic req_type make_req(logic op, int x, int y, int anchor);
      req_type r;
      r.operation = op;
      r.coord_x   = 16'(x);
      r.coord_y   = 16'(y);
      r.in_hue    = rand_hue(anchor);
      r.in_sat    = rand_chan();
      r.in_lum    = rand_chan();
      r.in_alpha  = rand_chan();
      return r;
   endfunction

   task automatic send_request(input req_type r, input logic typed, input rsp_type want);
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (r.operation == OP_PICK) begin
         pending_picks.push_back(typed ? want : downsample_pixel(r.coord_x, r.coord_y));
         pick_count++;
         useful_count++;
      end else if (store_pixel(r)) begin
         useful_count++;
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      tile_w = clamp_dim(w);
      tile_h = clamp_dim(h);
      phase_count++;
   endtask

   // load a 2x2 block when it is not fully known yet, and at random otherwise, then pick it through random coordinates
   task automatic tile_pick();
      logic [15:0] cx;
      logic [15:0] cy;
      int          bx;
      int          by;
      int          base;
      int          anchor;
      bit          ready;
      cx = 16'($urandom_range(65535));
      cy = 16'($urandom_range(65535));
      bx = (int'(cx) % (tile_w / 2)) * 2;
      by = (int'(cy) % (tile_h / 2)) * 2;
      base = by * IMG_MAX + bx;
      ready = pixel_loaded[base] && pixel_loaded[base + 1] &&
              pixel_loaded[base + IMG_MAX] && pixel_loaded[base + IMG_MAX + 1];
      if (!ready || $urandom_range(3) == 0) begin
         anchor = $urandom_range(HUE_FULL - 1);
         for (int k = 0; k < 4; k++)
            send_request(make_req(OP_LOAD, bx + k % 2, by + k / 2, anchor), 1'b0, '0);
      end
      send_request(make_req(OP_PICK, cx, cy, 0), 1'b0, '0);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 17);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_picks.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: hue %0d sat %0d lum %0d alpha %0d",
                        rsp_data.out_hue, rsp_data.out_sat, rsp_data.out_lum,
                        rsp_data.out_alpha);
         end else begin
            want = pending_picks.pop_front();
            if (rsp_data.out_hue !== want.out_hue || rsp_data.out_sat !== want.out_sat ||
                rsp_data.out_lum !== want.out_lum || rsp_data.out_alpha !== want.out_alpha)
            begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("pick mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           want.out_hue, want.out_sat, want.out_lum, want.out_alpha,
                           rsp_data.out_hue, rsp_data.out_sat, rsp_data.out_lum,
                           rsp_data.out_alpha);
            end
         end
      end
   end

   initial begin
      #3_000_000;
      $display("quarter_tile_hsla_downsample verification failed");
      $finish;
   end

   initial begin
      logic [DIM_W-1:0] phase_w [0:NUM_PHASES-1];
      logic [DIM_W-1:0] phase_h [0:NUM_PHASES-1];
      int               quota;
      int               half;
      int               roll;
      bit               drained;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_IMAGE_WIDTH;
      csr_wdata      = '0;
      calm           = 1'b0;
      mismatch_count = 0;
      pick_count     = 0;
      load_count     = 0;
      ignored_count  = 0;
      useful_count   = 0;
      phase_count    = 0;
      tile_w         = clamp_dim(IMAGE_DIM_RESET);
      tile_h         = clamp_dim(IMAGE_DIM_RESET);
      phase_w = '{9'd2, 9'd511, 9'd0, 9'd6, 9'd17, 9'd256, 9'd300, 9'd0};
      phase_h = '{9'd2, 9'd3, 9'd256, 9'd10, 9'd33, 9'd256, 9'd130, 9'd0};

      directed = '{
         mk(OP_LOAD, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 1, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 0, 1, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 1, 1, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         // outside the image, would alias onto the zero block if written
         mk(OP_LOAD, 256, 0, 46079, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 0, 256, 46079, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_PICK, 65408, 65280, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0),
         mk(OP_LOAD, 254, 254, 46079, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 255, 254, 46079, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 254, 255, 46079, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 255, 255, 46079, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_PICK, 65535, 65535, 0, 0, 0, 0, 1'b1, 46079, 65535, 65535, 65535),
         // hue at or above full circle folds back
         mk(OP_LOAD, 2, 0, 46080, 1, 1, 1, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 3, 0, 65535, 2, 2, 2, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 2, 1, 0, 3, 3, 3, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 3, 1, 19455, 4, 4, 4, 1'b0, 0, 0, 0, 0),
         mk(OP_PICK, 1, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         // exact half circle apart on both rows
         mk(OP_LOAD, 4, 0, 0, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 5, 0, 23040, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 4, 1, 40000, 65535, 65535, 65535, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 5, 1, 16960, 65534, 65534, 65534, 1'b0, 0, 0, 0, 0),
         mk(OP_PICK, 2, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         // mean across the zero crossing, one landing on the full circle
         mk(OP_LOAD, 6, 0, 46000, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 7, 0, 100, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 6, 1, 46079, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_LOAD, 7, 1, 1, 0, 0, 0, 1'b0, 0, 0, 0, 0),
         mk(OP_PICK, 3, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 0)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++)
         send_request(directed[i].stim, directed[i].typed, directed[i].want);
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 1)
            set_dims(DIM_W'($urandom_range(511)), DIM_W'($urandom_range(511)));
         else
            set_dims(phase_w[p], phase_h[p]);
         calm    = (p == 5);
         quota   = useful_count + PHASE_ITEMS;
         half    = useful_count + PHASE_ITEMS / 2;
         drained = 1'b0;
         while (useful_count < quota) begin
            if (!drained && useful_count >= half) begin
               settle();
               drained = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 60) begin
               tile_pick();
            end else if (roll < 80) begin
               send_request(make_req(OP_LOAD, $urandom_range(tile_w - 1),
                                     $urandom_range(tile_h - 1), $urandom_range(HUE_FULL - 1)),
                            1'b0, '0);
            end else if ($urandom_range(1)) begin
               send_request(make_req(OP_LOAD, $urandom_range(65535, tile_w),
                                     $urandom_range(65535), $urandom_range(HUE_FULL - 1)),
                            1'b0, '0);
            end else begin
               send_request(make_req(OP_LOAD, $urandom_range(65535),
                                     $urandom_range(65535, tile_h), $urandom_range(HUE_FULL - 1)),
                            1'b0, '0);
            end
         end
         settle();
      end
      calm = 1'b0;

      $display("checked %0d picks against %0d stored loads, %0d out-of-image loads dropped",
               pick_count, load_count, ignored_count);
      $display("ran %0d image size settings incl. 2x2, odd and oversized values",
               phase_count);
      if (mismatch_count == 0)
         $display("quarter_tile_hsla_downsample verification clean");
      else
         $display("quarter_tile_hsla_downsample verification failed");
      $finish;
   end

endmodule

`default_nettype wire

// ----- quarter_tile_hsla_downsample.f -----
src/qthd_pkg.sv
src/qthd_control.sv
src/qthd_datapath.sv
src/quarter_tile_hsla_downsample.sv
tb/testbench.sv
